[hdl/bri_pkg.sv]
// Shared types, constants and helper functions for the banked register file
// with exception entry and interrupt control. No dependencies.
`default_nettype none

package bri_pkg;

	localparam int unsigned DATA_W = 32;
	localparam int unsigned PHYS_N = 31;  // 16 user + 7 fast + 4 x 2 exception banks
	localparam int unsigned PHYS_W = 5;
	localparam int unsigned SAVED_N = 5;

	localparam logic [31:0] RESET_VECTOR = 32'hFFFF_0000;
	localparam logic [31:0] PC_RESET = RESET_VECTOR + 32'd4;
	localparam logic [31:0] STATUS_RESET = 32'h0000_00D3;
	localparam logic [31:0] MASK_MAIN = 32'h003F_3F7F;
	localparam logic [31:0] MASK_LEGACY = 32'h0000_3FFF;
	localparam logic [31:0] MASK_SECOND = 32'h01FF_3FFF;

	localparam logic [4:0] MODE_USR = 5'h10;
	localparam logic [4:0] MODE_FIQ = 5'h11;
	localparam logic [4:0] MODE_IRQ = 5'h12;
	localparam logic [4:0] MODE_SVC = 5'h13;
	localparam logic [4:0] MODE_ABT = 5'h17;
	localparam logic [4:0] MODE_UND = 5'h1B;
	localparam logic [4:0] MODE_SYS = 5'h1F;

	localparam logic [2:0] VEC_IRQ = 3'd6;

	typedef enum logic [3:0] {
		OP_READ    = 4'd0,
		OP_WRITE   = 4'd1,
		OP_STATUS  = 4'd2,
		OP_RAISE   = 4'd3,
		OP_MASTER  = 4'd4,
		OP_ENABLE  = 4'd5,
		OP_ACK     = 4'd6,
		OP_EXCEPT  = 4'd7,
		OP_SERVICE = 4'd8
	} op_t;

	typedef enum logic [1:0] {
		CFG_CORE_SELECT    = 2'd0,
		CFG_LEGACY_MODE    = 2'd1,
		CFG_EXCEPTION_BASE = 2'd2
	} cfg_idx_t;

	typedef enum logic [2:0] {
		BANK_USER  = 3'd0,
		BANK_FAST  = 3'd1,
		BANK_IRQ   = 3'd2,
		BANK_SUPER = 3'd3,
		BANK_ABORT = 3'd4,
		BANK_UNDEF = 3'd5
	} bank_t;

	typedef struct packed {
		logic              en;
		logic [PHYS_W-1:0] addr;
		logic [31:0]       data;
	} bri_wr_t;

	typedef struct packed {
		logic  known;
		bank_t bank;
	} mode_dec_t;

	// Physical slot of an architectural register in the given bank.
	// Layout: user 0..15, fast 16..22, irq 23..24, super 25..26,
	// abort 27..28, undefined 29..30.
	function automatic logic [PHYS_W-1:0] phys_index(bank_t bank, logic [3:0] idx);
		logic [PHYS_W-1:0] r;
		logic              hi;
		r = {1'b0, idx};
		hi = (idx == 4'd13) || (idx == 4'd14);
		case (bank)
			BANK_FAST: begin
				if (idx >= 4'd8 && idx <= 4'd14) r = {1'b0, idx} + 5'd8;
			end
			BANK_IRQ: begin
				if (hi) r = {1'b0, idx} + 5'd10;
			end
			BANK_SUPER: begin
				if (hi) r = {1'b0, idx} + 5'd12;
			end
			BANK_ABORT: begin
				if (hi) r = {1'b0, idx} + 5'd14;
			end
			BANK_UNDEF: begin
				if (hi) r = {1'b0, idx} + 5'd16;
			end
			default: r = {1'b0, idx};
		endcase
		return r;
	endfunction

	function automatic mode_dec_t decode_mode(logic [4:0] m);
		mode_dec_t d;
		d.known = 1'b1;
		d.bank = BANK_USER;
		case (m)
			MODE_USR, MODE_SYS: d.bank = BANK_USER;
			MODE_FIQ: d.bank = BANK_FAST;
			MODE_IRQ: d.bank = BANK_IRQ;
			MODE_SVC: d.bank = BANK_SUPER;
			MODE_ABT: d.bank = BANK_ABORT;
			MODE_UND: d.bank = BANK_UNDEF;
			default: d.known = 1'b0;
		endcase
		return d;
	endfunction

	// Mode entered by each exception vector.
	function automatic logic [4:0] vector_mode(logic [2:0] vec);
		logic [4:0] m;
		case (vec)
			3'd0: m = MODE_SVC;
			3'd1: m = MODE_UND;
			3'd2: m = MODE_SVC;
			3'd3: m = MODE_ABT;
			3'd4: m = MODE_ABT;
			3'd5: m = MODE_SVC;
			3'd6: m = MODE_IRQ;
			default: m = MODE_FIQ;
		endcase
		return m;
	endfunction

endpackage

`default_nettype wire

[hdl/bri_regfile.sv]
// Physical register storage for all banks: one banked read port, one
// general write port and a dedicated program counter write port. Uses bri_pkg.
`default_nettype none

module bri_regfile (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic [bri_pkg::PHYS_W-1:0]    rd_addr,
	output logic [31:0]                        rd_data,
	output logic [31:0]                        pc,
	input  wire bri_pkg::bri_wr_t              wr,
	input  wire logic                          pc_wr_en,
	input  wire logic [31:0]                   pc_wr_data
);
	import bri_pkg::*;

	localparam logic [PHYS_W-1:0] PC_SLOT = 5'd15;

	logic [31:0] regs_q [PHYS_N];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < PHYS_N; i++) begin
				regs_q[i] <= (i == int'(PC_SLOT)) ? PC_RESET : 32'b0;
			end
		end else begin
			if (wr.en) begin
				regs_q[wr.addr] <= wr.data;
			end
			if (pc_wr_en) begin
				regs_q[PC_SLOT] <= pc_wr_data;
			end
		end
	end

	assign rd_data = regs_q[rd_addr];
	// The program counter is never banked.
	assign pc = regs_q[PC_SLOT];

endmodule

`default_nettype wire

[hdl/banked_registers_exception_irq.sv]
// A command is captured in the input register and then written to the state and
// result registers, where done marks it; one command is taken in every cycle and busy
// stays low. Reset clears the valid bits, the register file, the state and
// configuration registers to their architectural reset values at once, but not the
// payload of the input and result registers; the result strobe cannot be stalled.
`default_nettype none

module banked_registers_exception_irq (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [3:0]  operation,
	input  wire logic [3:0]  reg_index,
	input  wire logic [31:0] value,
	input  wire logic [31:0] mask,
	input  wire logic        save_status,
	input  wire logic [2:0]  vector_index,
	input  wire logic [4:0]  irq_line,
	output logic             done,
	output logic [31:0]      read_data,
	output logic [31:0]      status_word,
	output logic [31:0]      saved_word,
	output logic             has_saved,
	output logic             irq_request,
	output logic [1:0]       irq_delay,
	output logic             wake,
	output logic             exception_taken,
	output logic             mode_error,
	output logic [31:0]      enable_word,
	output logic [31:0]      flag_word,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [3:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);
	import bri_pkg::*;

	// Configuration registers.
	logic        core_sel_q;
	logic        legacy_q;
	logic [31:0] exc_base_q;
	cfg_idx_t    cfg_idx;

	// Input stage.
	logic        v_s1;
	logic [3:0]  op_s1;
	logic [3:0]  ridx_s1;
	logic [31:0] val_s1;
	logic [31:0] msk_s1;
	logic        save_s1;
	logic [2:0]  vec_s1;
	logic [4:0]  line_s1;

	// Architectural state outside the register file.
	logic [31:0] status_q;
	bank_t       bank_q;
	logic        me_q;
	logic [31:0] en_q;
	logic [31:0] flag_q;
	logic [31:0] saved_q [SAVED_N];

	// Result stage.
	logic        done_s2;
	logic [31:0] rd_s2;
	logic        req_s2;
	logic [1:0]  delay_s2;
	logic        wake_s2;
	logic        taken_s2;
	logic        merr_s2;

	// Datapath.
	op_t               op;
	logic [PHYS_W-1:0] rd_addr;
	logic [31:0]       rd_data;
	logic [31:0]       pc;
	bri_wr_t           wr;
	logic              pc_wr_en;
	logic [31:0]       pc_wr_data;
	logic              irq_rdy;
	logic              exc;
	logic [2:0]        exc_vec;
	logic              sw_en;
	logic              sw_save;
	logic [31:0]       sw_val;
	mode_dec_t         mdec;
	logic              mode_chg;
	bank_t             bank_n;
	logic              has_saved_n;
	logic [2:0]        sidx_n;
	logic              saved_wr;
	logic [31:0]       saved_after;
	logic [31:0]       status_n;
	logic              me_n;
	logic [31:0]       en_n;
	logic [31:0]       flag_n;
	logic [31:0]       core_mask;
	logic [31:0]       en_mask;
	logic              req;
	logic              wk;
	logic              merr;
	logic [31:0]       exc_base;
	logic [2:0]        cur_sidx;

	bri_regfile u_regfile (
		.clk        (clk),
		.arst_n     (arst_n),
		.rd_addr    (rd_addr),
		.rd_data    (rd_data),
		.pc         (pc),
		.wr         (wr),
		.pc_wr_en   (pc_wr_en),
		.pc_wr_data (pc_wr_data)
	);

	// Configuration port.
	assign pready = 1'b1;
	assign cfg_idx = cfg_idx_t'(paddr[3:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			core_sel_q <= 1'b0;
			legacy_q <= 1'b0;
			exc_base_q <= RESET_VECTOR;
		end else if (psel && penable && pwrite && pready) begin
			case (cfg_idx)
				CFG_CORE_SELECT: core_sel_q <= pwdata[0];
				CFG_LEGACY_MODE: legacy_q <= pwdata[0];
				CFG_EXCEPTION_BASE: exc_base_q <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		case (cfg_idx)
			CFG_CORE_SELECT: prdata = {31'b0, core_sel_q};
			CFG_LEGACY_MODE: prdata = {31'b0, legacy_q};
			CFG_EXCEPTION_BASE: prdata = exc_base_q;
			default: prdata = '0;
		endcase
	end

	// Input register.
	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			op_s1 <= operation;
			ridx_s1 <= reg_index;
			val_s1 <= value;
			msk_s1 <= mask;
			save_s1 <= save_status;
			vec_s1 <= vector_index;
			line_s1 <= irq_line;
		end
	end

	// Command execution.
	assign op = op_t'(op_s1);
	assign rd_addr = phys_index(bank_q, ridx_s1);
	assign irq_rdy = me_q && ((en_q & flag_q) != '0) && !status_q[7];
	assign exc = (op == OP_EXCEPT) || ((op == OP_SERVICE) && irq_rdy);
	assign exc_vec = (op == OP_EXCEPT) ? vec_s1 : VEC_IRQ;
	assign sw_en = (op == OP_STATUS) || exc;
	assign sw_save = exc ? 1'b1 : save_s1;
	assign sw_val = exc ? ((status_q & ~32'h3F) | 32'h80 | {27'b0, vector_mode(exc_vec)})
	                    : val_s1;

	// Mode switch on a status write; an unknown new mode keeps the bank.
	assign mdec = decode_mode(sw_val[4:0]);
	assign mode_chg = sw_en && (sw_val[4:0] != status_q[4:0]);
	assign bank_n = (mode_chg && mdec.known) ? mdec.bank : bank_q;
	assign merr = (op == OP_STATUS) && mode_chg && !mdec.known;
	assign has_saved_n = (bank_n != BANK_USER);
	assign sidx_n = 3'(bank_n) - 3'd1;
	assign saved_wr = sw_en && sw_save && has_saved_n;
	assign saved_after = saved_wr ? status_q : saved_q[sidx_n];
	assign status_n = sw_en ? sw_val : status_q;

	assign exc_base = core_sel_q ? 32'b0 : exc_base_q;
	assign core_mask = !core_sel_q ? MASK_MAIN : (legacy_q ? MASK_LEGACY : MASK_SECOND);
	assign en_mask = msk_s1 & core_mask;

	always_comb begin
		me_n = me_q;
		en_n = en_q;
		flag_n = flag_q;
		req = 1'b0;
		wk = 1'b0;
		case (op)
			OP_STATUS: req = me_q && ((en_q & flag_q) != '0) && !sw_val[7];
			OP_RAISE: begin
				flag_n = flag_q | (32'b1 << line_s1);
				if ((en_q & flag_n) != '0) begin
					if (me_q && !status_q[7]) req = 1'b1;
					else if (me_q || core_sel_q) wk = 1'b1;
				end
			end
			OP_MASTER: begin
				me_n = val_s1[0];
				req = val_s1[0] && ((en_q & flag_q) != '0) && !status_q[7];
			end
			OP_ENABLE: begin
				en_n = (en_q & ~en_mask) | (val_s1 & en_mask);
				req = me_q && ((en_n & flag_q) != '0) && !status_q[7];
			end
			OP_ACK: flag_n = flag_q & ~(val_s1 & msk_s1);
			OP_SERVICE: wk = irq_rdy;
			default: ;
		endcase
	end

	// Register file writes: a plain register write, or the link register of
	// the entered bank plus the realigned program counter on exception entry.
	always_comb begin
		wr.en = 1'b0;
		wr.addr = rd_addr;
		wr.data = val_s1;
		if (v_s1 && (op == OP_WRITE)) begin
			wr.en = 1'b1;
		end else if (v_s1 && exc) begin
			wr.en = 1'b1;
			wr.addr = phys_index(bank_n, 4'd14);
			wr.data = pc + {30'b0, saved_after[5], 1'b0};
		end
	end

	assign pc_wr_en = v_s1 && exc;
	assign pc_wr_data = {exc_base[31:2], 2'b00} + {27'b0, exc_vec, 2'b00} + 32'd4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			status_q <= STATUS_RESET;
			bank_q <= BANK_SUPER;
			me_q <= 1'b0;
			en_q <= '0;
			flag_q <= '0;
			for (int i = 0; i < SAVED_N; i++) begin
				saved_q[i] <= '0;
			end
		end else if (v_s1) begin
			status_q <= status_n;
			bank_q <= bank_n;
			me_q <= me_n;
			en_q <= en_n;
			flag_q <= flag_n;
			if (saved_wr) begin
				saved_q[sidx_n] <= status_q;
			end
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_s2 <= 1'b0;
		end else begin
			done_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s1) begin
			rd_s2 <= (op == OP_READ) ? rd_data : 32'b0;
			req_s2 <= req;
			delay_s2 <= (req && core_sel_q && !legacy_q) ? 2'd2 : 2'd1;
			wake_s2 <= wk;
			taken_s2 <= exc;
			merr_s2 <= merr;
		end
	end

	// The state registers already hold the outcome of the transfer shown by done.
	assign cur_sidx = 3'(bank_q) - 3'd1;

	assign done = done_s2;
	assign read_data = rd_s2;
	assign irq_request = req_s2;
	assign irq_delay = delay_s2;
	assign wake = wake_s2;
	assign exception_taken = taken_s2;
	assign mode_error = merr_s2;
	assign status_word = status_q;
	assign has_saved = (bank_q != BANK_USER);
	assign saved_word = (bank_q != BANK_USER) ? saved_q[cur_sidx] : 32'b0;
	assign enable_word = en_q;
	assign flag_word = flag_q;

endmodule

`default_nettype wire

[verif/bri_bank_monitor.sv]
`timescale 1ns / 1ps
// Watches the command, result and APB channels of the banked register file,
// keeps its own copy of banks, status and interrupt state and compares every result.
// Depends on bri_pkg for operation, bank and configuration codes and reset constants.

module bri_bank_monitor (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic        busy,
	input  wire logic [3:0]  operation,
	input  wire logic [3:0]  reg_index,
	input  wire logic [31:0] value,
	input  wire logic [31:0] mask,
	input  wire logic        save_status,
	input  wire logic [2:0]  vector_index,
	input  wire logic [4:0]  irq_line,
	input  wire logic        done,
	input  wire logic [31:0] read_data,
	input  wire logic [31:0] status_word,
	input  wire logic [31:0] saved_word,
	input  wire logic        has_saved,
	input  wire logic        irq_request,
	input  wire logic [1:0]  irq_delay,
	input  wire logic        wake,
	input  wire logic        exception_taken,
	input  wire logic        mode_error,
	input  wire logic [31:0] enable_word,
	input  wire logic [31:0] flag_word,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [3:0]  paddr,
	input  wire logic [31:0] pwdata,
	input  wire logic        pready,
	output int               mismatch_count,
	output int               pending_count
);
	import bri_pkg::*;

	localparam int REG_SP = 13;
	localparam int REG_LR = 14;
	localparam int REG_PC = 15;
	localparam int FIRST_FAST_REG = 8;
	localparam int FAST_SLOT0 = 16;
	localparam int PAIR_SLOT0 = 23;
	localparam int IRQ_MASK_BIT = 7;
	localparam int THUMB_BIT = 5;
	// Mode entered per vector, vector 0 in the low five bits.
	localparam logic [39:0] ENTRY_MODES = {MODE_FIQ, MODE_IRQ, MODE_SVC, MODE_ABT,
		MODE_ABT, MODE_SVC, MODE_UND, MODE_SVC};

	typedef struct packed {
		logic [31:0] read_data;
		logic [31:0] status_word;
		logic [31:0] saved_word;
		logic        has_saved;
		logic        irq_request;
		logic [1:0]  irq_delay;
		logic        wake;
		logic        exception_taken;
		logic        mode_error;
		logic [31:0] enable_word;
		logic [31:0] flag_word;
	} cmd_outcome_t;

	// Physical registers: user 0..15, fast 16..22, then two each for irq, super,
	// abort and undefined.
	logic [31:0] gpr [0:30];
	logic [31:0] saved_sr [0:4];
	logic [31:0] status_r, enable_r, flag_r, exc_base;
	logic        master_r, core_sel, legacy;
	bank_t       bank;
	cmd_outcome_t outcome_fifo [$];

	function automatic int slot_of(logic [3:0] idx);
		if (bank == BANK_FAST && idx >= FIRST_FAST_REG && idx != REG_PC)
			return FAST_SLOT0 + int'(idx) - FIRST_FAST_REG;
		if ((idx == REG_SP || idx == REG_LR) && bank != BANK_USER && bank != BANK_FAST)
			return PAIR_SLOT0 + 2 * (int'(bank) - int'(BANK_IRQ)) + int'(idx) - REG_SP;
		return int'(idx);
	endfunction

	function automatic logic [31:0] current_saved();
		return saved_sr[bank == BANK_USER ? 0 : int'(bank) - 1];
	endfunction

	function automatic logic irq_armed();
		return master_r && (enable_r & flag_r) != '0 && !status_r[IRQ_MASK_BIT];
	endfunction

	task automatic reset_state();
		for (int i = 0; i < 31; i++) gpr[i] = '0;
		for (int i = 0; i < 5; i++) saved_sr[i] = '0;
		gpr[REG_PC] = PC_RESET;
		status_r = STATUS_RESET;
		bank = BANK_SUPER;
		master_r = 1'b0;
		enable_r = '0;
		flag_r = '0;
		core_sel = 1'b0;
		legacy = 1'b0;
		exc_base = RESET_VECTOR;
	endtask

	task automatic set_status(input logic [31:0] nv, input logic save, output logic bad);
		bad = 1'b0;
		// An unknown mode only counts as an error when the mode bits actually change.
		if (nv[4:0] != status_r[4:0]) begin
			case (nv[4:0])
				MODE_USR, MODE_SYS: bank = BANK_USER;
				MODE_FIQ: bank = BANK_FAST;
				MODE_IRQ: bank = BANK_IRQ;
				MODE_SVC: bank = BANK_SUPER;
				MODE_ABT: bank = BANK_ABORT;
				MODE_UND: bank = BANK_UNDEF;
				default: bad = 1'b1;
			endcase
		end
		if (save && bank != BANK_USER) saved_sr[int'(bank) - 1] = status_r;
		status_r = nv;
	endtask

	task automatic enter_exception(input logic [2:0] vec);
		logic        ignored;
		logic [31:0] ret_pc, target;
		set_status((status_r & ~32'h3F) | 32'h80 | 32'(ENTRY_MODES[int'(vec) * 5 +: 5]),
			1'b1, ignored);
		ret_pc = gpr[slot_of(REG_PC)];
		gpr[slot_of(REG_LR)] = ret_pc + (current_saved() & (32'd1 << THUMB_BIT) ? 32'd2 : 32'd0);
		target = (core_sel ? 32'd0 : exc_base) + {27'd0, vec, 2'b00};
		gpr[slot_of(REG_PC)] = (target & ~32'h3) + 32'd4;
	endtask

	task automatic execute_command(input logic [3:0] op, input logic [3:0] idx,
			input logic [31:0] val, input logic [31:0] msk, input logic save,
			input logic [2:0] vec, input logic [4:0] line, output cmd_outcome_t o);
		logic [31:0] en_mask;
		logic        bad;
		o = '0;
		case (op)
			OP_READ: o.read_data = gpr[slot_of(idx)];
			OP_WRITE: gpr[slot_of(idx)] = val;
			OP_STATUS: begin
				set_status(val, save, bad);
				o.mode_error = bad;
				o.irq_request = irq_armed();
			end
			OP_RAISE: begin
				flag_r[line] = 1'b1;
				if ((enable_r & flag_r) != '0) begin
					if (master_r && !status_r[IRQ_MASK_BIT]) o.irq_request = 1'b1;
					else if (master_r || core_sel) o.wake = 1'b1;
				end
			end
			OP_MASTER: begin
				master_r = val[0];
				o.irq_request = irq_armed();
			end
			OP_ENABLE: begin
				en_mask = msk & (core_sel ? (legacy ? MASK_LEGACY : MASK_SECOND) : MASK_MAIN);
				enable_r = (enable_r & ~en_mask) | (val & en_mask);
				o.irq_request = irq_armed();
			end
			OP_ACK: flag_r = flag_r & ~(val & msk);
			OP_EXCEPT: begin
				enter_exception(vec);
				o.exception_taken = 1'b1;
			end
			OP_SERVICE: begin
				if (irq_armed()) begin
					enter_exception(VEC_IRQ);
					o.exception_taken = 1'b1;
					o.wake = 1'b1;
				end
			end
			default: ;
		endcase
		o.status_word = status_r;
		o.has_saved = bank != BANK_USER;
		o.saved_word = o.has_saved ? current_saved() : '0;
		o.irq_delay = (o.irq_request && core_sel && !legacy) ? 2'd2 : 2'd1;
		o.enable_word = enable_r;
		o.flag_word = flag_r;
	endtask

	task automatic cmp(input string what, input logic [31:0] want, input logic [31:0] got);
		if (got !== want) begin
			mismatch_count++;
			$display("%0t: %s expected %h got %h", $time, what, want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		cmd_outcome_t want;
		if (!arst_n) begin
			reset_state();
			outcome_fifo.delete();
			mismatch_count = 0;
			pending_count = 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (paddr[3:2])
					CFG_CORE_SELECT: core_sel = pwdata[0];
					CFG_LEGACY_MODE: legacy = pwdata[0];
					CFG_EXCEPTION_BASE: exc_base = pwdata;
					default: ;
				endcase
			end
			// The result of an older transfer is retired before a new one is queued.
			if (done === 1'b1) begin
				if (outcome_fifo.size() == 0) begin
					mismatch_count++;
					$display("%0t: result with none outstanding, expected none got status %h",
						$time, status_word);
				end else begin
					want = outcome_fifo.pop_front();
					cmp("read_data", want.read_data, read_data);
					cmp("status_word", want.status_word, status_word);
					cmp("saved_word", want.saved_word, saved_word);
					cmp("has_saved", 32'(want.has_saved), 32'(has_saved));
					cmp("irq_request", 32'(want.irq_request), 32'(irq_request));
					cmp("irq_delay", 32'(want.irq_delay), 32'(irq_delay));
					cmp("wake", 32'(want.wake), 32'(wake));
					cmp("exception_taken", 32'(want.exception_taken), 32'(exception_taken));
					cmp("mode_error", 32'(want.mode_error), 32'(mode_error));
					cmp("enable_word", want.enable_word, enable_word);
					cmp("flag_word", want.flag_word, flag_word);
				end
			end
			if (start && !busy) begin
				execute_command(operation, reg_index, value, mask, save_status, vector_index,
					irq_line, want);
				outcome_fifo.push_back(want);
			end
			pending_count = outcome_fifo.size();
		end
	end

endmodule

[verif/banked_registers_exception_irq_tb.sv]
`timescale 1ns / 1ps
// Top of the banked register file testbench: clock, reset, commands, APB writes.
// Depends on bri_pkg, the block under test and bri_bank_monitor.

module banked_registers_exception_irq_tb;
	import bri_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam logic [3:0] OP_TOP_CODE = 4'hF;  // highest operation code, unused
	localparam int REG_MIN_LINK = 13;
	localparam int REG_MAX_PC = 15;

	logic        clk, arst_n, start;
	logic [3:0]  operation, reg_index;
	logic [31:0] value, mask;
	logic        save_status;
	logic [2:0]  vector_index;
	logic [4:0]  irq_line;
	logic        psel, penable, pwrite;
	logic [3:0]  paddr;
	logic [31:0] pwdata;

	wire logic        busy, done, has_saved, irq_request, wake, exception_taken, mode_error;
	wire logic        pready;
	wire logic [1:0]  irq_delay;
	wire logic [31:0] read_data, status_word, saved_word, enable_word, flag_word, prdata;

	int mismatch_count, pending_count;
	int cycle_count = 0;
	int items_sent = 0;
	int gap_rate = 0;

	banked_registers_exception_irq u_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.operation(operation), .reg_index(reg_index), .value(value), .mask(mask),
		.save_status(save_status), .vector_index(vector_index), .irq_line(irq_line),
		.done(done), .read_data(read_data), .status_word(status_word),
		.saved_word(saved_word), .has_saved(has_saved), .irq_request(irq_request),
		.irq_delay(irq_delay), .wake(wake), .exception_taken(exception_taken),
		.mode_error(mode_error), .enable_word(enable_word), .flag_word(flag_word),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	bri_bank_monitor u_bank_monitor (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.operation(operation), .reg_index(reg_index), .value(value), .mask(mask),
		.save_status(save_status), .vector_index(vector_index), .irq_line(irq_line),
		.done(done), .read_data(read_data), .status_word(status_word),
		.saved_word(saved_word), .has_saved(has_saved), .irq_request(irq_request),
		.irq_delay(irq_delay), .wake(wake), .exception_taken(exception_taken),
		.mode_error(mode_error), .enable_word(enable_word), .flag_word(flag_word),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .pready(pready),
		.mismatch_count(mismatch_count), .pending_count(pending_count)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	task automatic send(input logic [3:0] op, input logic [3:0] idx, input logic [31:0] val,
			input logic [31:0] msk, input logic save, input logic [2:0] vec,
			input logic [4:0] line);
		@(negedge clk);
		operation <= op;
		reg_index <= idx;
		value <= val;
		mask <= msk;
		save_status <= save;
		vector_index <= vec;
		irq_line <= line;
		start <= 1'b1;
		do @(posedge clk); while (busy !== 1'b0);
		items_sent++;
		if (gap_rate != 0 && $urandom_range(0, 15) < gap_rate)
			repeat ($urandom_range(1, 15)) @(negedge clk) start <= 1'b0;
	endtask

	// Stops sending until every queued result has come back.
	task automatic drain();
		@(negedge clk) start <= 1'b0;
		while (pending_count != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic cfg_write(input cfg_idx_t idx, input logic [31:0] data);
		drain();
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= data;
		@(negedge clk) penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	function automatic logic [4:0] pick_mode();
		case ($urandom_range(0, 6))
			0: return MODE_USR;
			1: return MODE_FIQ;
			2: return MODE_IRQ;
			3: return MODE_SVC;
			4: return MODE_ABT;
			5: return MODE_UND;
			default: return MODE_SYS;
		endcase
	endfunction

	task automatic rand_item();
		logic [31:0] val, msk;
		logic [3:0]  idx;
		logic        sv;
		logic [2:0]  vec;
		logic [4:0]  ln;
		int          pick;
		val = $urandom;
		msk = $urandom;
		idx = 4'($urandom);
		sv = 1'($urandom);
		vec = 3'($urandom);
		ln = 5'($urandom);
		pick = $urandom_range(0, 99);
		if (pick < 14) begin
			send(OP_READ, idx, val, msk, sv, vec, ln);
		end else if (pick < 28) begin
			send(OP_WRITE, idx, val, msk, sv, vec, ln);
		end else if (pick < 42) begin
			if ($urandom_range(0, 4) != 0) val[4:0] = pick_mode();
			send(OP_STATUS, idx, val, msk, sv, vec, ln);
		end else if (pick < 54) begin
			send(OP_RAISE, idx, val, msk, sv, vec, ln);
		end else if (pick < 60) begin
			send(OP_MASTER, idx, val, msk, sv, vec, ln);
		end else if (pick < 70) begin
			if ($urandom_range(0, 1) == 0) msk = '1;
			send(OP_ENABLE, idx, val, msk, sv, vec, ln);
		end else if (pick < 78) begin
			if ($urandom_range(0, 3) == 0) begin
				val = '1;
				msk = '1;
			end
			send(OP_ACK, idx, val, msk, sv, vec, ln);
		end else if (pick < 88) begin
			send(OP_EXCEPT, idx, val, msk, sv, vec, ln);
		end else if (pick < 97) begin
			send(OP_SERVICE, idx, val, msk, sv, vec, ln);
		end else begin
			send(4'($urandom_range(OP_SERVICE + 1, OP_TOP_CODE)), idx, val, msk, sv, vec, ln);
		end
	endtask

	// Enable, unmask and raise a line, then service it: the path to interrupt entry.
	task automatic irq_flow();
		logic [4:0]  line;
		logic [31:0] st;
		logic [3:0]  idx;
		logic        sv;
		logic [2:0]  vec;
		logic [4:0]  ln;
		idx = 4'($urandom);
		sv = 1'($urandom);
		vec = 3'($urandom);
		ln = 5'($urandom);
		line = ($urandom_range(0, 3) != 0) ? 5'($urandom_range(0, 13)) : 5'($urandom);
		send(OP_ENABLE, idx, $urandom | (32'd1 << line),
			$urandom_range(0, 1) ? '1 : ($urandom | (32'd1 << line)), sv, vec, ln);
		send(OP_MASTER, idx, ($urandom & ~32'd1) | 32'($urandom_range(0, 5) != 0), $urandom,
			sv, vec, ln);
		st = $urandom;
		st[4:0] = pick_mode();
		st[7] = ($urandom_range(0, 3) == 0);
		send(OP_STATUS, idx, st, $urandom, sv, vec, ln);
		send(OP_RAISE, idx, $urandom, $urandom, sv, vec, line);
		if ($urandom_range(0, 3) == 0) rand_item();
		send(OP_SERVICE, idx, $urandom, $urandom, sv, vec, ln);
		if ($urandom_range(0, 1) == 0)
			send(OP_READ, 4'($urandom_range(REG_MIN_LINK, REG_MAX_PC)), $urandom, $urandom,
				sv, vec, ln);
		if ($urandom_range(0, 1) == 0)
			send(OP_ACK, idx, $urandom_range(0, 1) ? '1 : (32'd1 << line), '1, sv, vec, ln);
	endtask

	task automatic run_random(input int n, input bit quiet);
		int stop;
		stop = items_sent + n;
		while (items_sent < stop) begin
			if (quiet) gap_rate = 0;
			else if ($urandom_range(0, 19) == 0) gap_rate = $urandom_range(0, 2) * 4;
			if ($urandom_range(0, 2) == 0) irq_flow();
			else rand_item();
		end
	endtask

	task automatic run_phase(input int n, input bit quiet);
		run_random(n / 2, quiet);
		drain();
		run_random(n - n / 2, quiet);
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		operation = '0;
		reg_index = '0;
		value = '0;
		mask = '0;
		save_status = 1'b0;
		vector_index = '0;
		irq_line = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		repeat (7) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		// Directed: reset values, raw pc write, bank switches, unknown modes, interrupt entry.
		send(OP_READ, 4'd15, '0, '0, 1'b0, 3'd0, 5'd0);
		send(OP_WRITE, 4'd15, '1, '1, 1'b1, 3'd7, 5'd31);
		send(OP_READ, 4'd15, '0, '0, 1'b0, 3'd0, 5'd0);
		send(OP_WRITE, 4'd14, '1, '0, 1'b0, 3'd0, 5'd0);
		send(OP_STATUS, 4'd0, {27'd0, MODE_FIQ}, '0, 1'b1, 3'd0, 5'd0);
		send(OP_WRITE, 4'd8, 32'hA5A5_A5A5, '0, 1'b0, 3'd0, 5'd0);
		send(OP_READ, 4'd8, '0, '0, 1'b0, 3'd0, 5'd0);
		send(OP_STATUS, 4'd0, 32'h0000_0005, '0, 1'b1, 3'd0, 5'd0);
		send(OP_STATUS, 4'd0, 32'h0000_0005, '0, 1'b0, 3'd0, 5'd0);
		send(OP_STATUS, 4'd0, {27'd0, MODE_USR}, '0, 1'b1, 3'd0, 5'd0);
		send(OP_STATUS, 4'd0, {27'd0, MODE_SYS}, '0, 1'b0, 3'd0, 5'd0);
		send(OP_ENABLE, 4'd0, '1, '1, 1'b0, 3'd0, 5'd0);
		send(OP_RAISE, 4'd0, '0, '0, 1'b0, 3'd0, 5'd0);
		send(OP_MASTER, 4'd0, 32'd1, '0, 1'b0, 3'd0, 5'd0);
		send(OP_RAISE, 4'd0, '0, '0, 1'b0, 3'd0, 5'd31);
		send(OP_SERVICE, 4'd0, '0, '0, 1'b0, 3'd0, 5'd0);
		send(OP_SERVICE, 4'd0, '0, '0, 1'b0, 3'd0, 5'd0);
		send(OP_ACK, 4'd0, '1, '0, 1'b0, 3'd0, 5'd0);
		send(OP_ACK, 4'd0, '1, '1, 1'b0, 3'd0, 5'd0);
		send(OP_EXCEPT, 4'd0, '0, '0, 1'b0, 3'd0, 5'd0);
		send(OP_EXCEPT, 4'd0, '0, '0, 1'b0, 3'd1, 5'd0);
		send(OP_EXCEPT, 4'd0, '0, '0, 1'b0, 3'd6, 5'd0);
		send(OP_EXCEPT, 4'd0, '0, '0, 1'b0, 3'd7, 5'd0);
		send(OP_SERVICE + 4'd1, 4'd0, '0, '0, 1'b0, 3'd0, 5'd0);
		send(OP_TOP_CODE, 4'd15, '1, '1, 1'b1, 3'd7, 5'd31);

		run_phase(220, 1'b0);
		cfg_write(CFG_CORE_SELECT, 32'd1);
		run_phase(220, 1'b0);
		cfg_write(CFG_LEGACY_MODE, 32'd1);
		run_phase(220, 1'b0);
		cfg_write(CFG_CORE_SELECT, 32'd0);
		cfg_write(CFG_EXCEPTION_BASE, 32'd0);
		run_phase(220, 1'b0);
		cfg_write(CFG_LEGACY_MODE, 32'd0);
		cfg_write(CFG_EXCEPTION_BASE, '1);
		run_phase(220, 1'b0);
		cfg_write(CFG_EXCEPTION_BASE, $urandom);
		run_phase(220, 1'b1);

		drain();
		repeat (8) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
